// ===== rtl/ilid_pkg.sv =====
package ilid_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = 11;
   localparam int POS_W    = 11;
   localparam int VAL_W    = 32;
   localparam int ACT_W    = 3;
   localparam int STAT_W   = 2;

   localparam logic [ACT_W-1:0] ACT_READ     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd1;
   localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd2;
   localparam logic [ACT_W-1:0] ACT_INS_AT   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef struct packed {
      logic [ACT_W-1:0]        action;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [STAT_W-1:0]       status;
      logic [CNT_W-1:0]        element_count;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [VAL_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_ctl_type;

endpackage

// ===== rtl/ilid_ram.sv =====
module ilid_ram
   import ilid_pkg::*;
(
   input  logic              clock,
   input  ram_ctl_type       ctl,
   output logic [VAL_W-1:0]  rd_data
);

   logic [VAL_W-1:0] mem [CAPACITY];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/indexed_list_insert_delete_core.sv =====
// Ordered list of signed 32-bit values held packed in a single-port-pair RAM,
// entry 0 at the head. One request on req_ (valid/stall) reads a position,
// inserts at head, tail or a position, or deletes a position; exactly one
// response follows on rsp_ with the read value, a status and the new count.
// req_stall is high from the accept until the response is loaded into the
// output register, so one request is in flight at a time.
// Each request runs through these states in order, one RAM move per cycle:
//   read: S_READ, S_RESP; insert at p: S_SHUP moves the count - p entries
//   from p up by one, S_PUT writes the value, S_RESP; delete at p: S_SHDN
//   moves the entries above p down by one, S_RESP; rejected or unknown action: S_RESP.
// The next request can be accepted in the cycle after the response loads.
// The longest request, an insert at the head of a list one short of full,
// is set by the shift of entries through the RAM.
// A held response in the output register does not block a new accept; the
// sequencer only waits at the end of a request while rsp_stall holds the
// previous response. Reset empties the list (count zero); the RAM contents
// are not cleared and are never read above the count.
module indexed_list_insert_delete_core
   import ilid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_SHUP = 3'd2;
   localparam logic [2:0] S_PUT  = 3'd3;
   localparam logic [2:0] S_SHDN = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   ram_ctl_type       ram_ctl;
   logic [VAL_W-1:0]  rd_data;
   logic              req_acc;
   logic [CNT_W-1:0]  ins_pos;
   logic [CNT_W-1:0]  idx_dec;
   logic [CNT_W-1:0]  idx_inc;

   ilid_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign idx_dec   = idx_ff - CNT_W'(1);
   assign idx_inc   = idx_ff + CNT_W'(1);

   always_comb begin
      unique case (req_data.action)
         ACT_INS_HEAD: ins_pos = '0;
         ACT_INS_TAIL: ins_pos = count_ff;
         default:      ins_pos = req_data.position;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      pend_in      = pend_ff;
      wr_addr_in   = wr_addr_ff;
      status_in    = status_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_ctl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               rd_ok_in  = 1'b0;
               status_in = ST_DONE;
               pend_in   = 1'b0;
               val_in    = req_data.item_value;
               state_in  = S_RESP;
               case (req_data.action)
                  ACT_READ: begin
                     if (req_data.position < count_ff) begin
                        pos_in   = req_data.position;
                        rd_ok_in = 1'b1;
                        state_in = S_READ;
                     end else begin
                        status_in = ST_RANGE;
                     end
                  end
                  ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
                     if (ins_pos > count_ff) begin
                        status_in = ST_RANGE;
                     end else if (count_ff >= CAP_COUNT) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in   = ins_pos;
                        idx_in   = count_ff;
                        state_in = S_SHUP;
                     end
                  end
                  ACT_DELETE: begin
                     if (req_data.position < count_ff) begin
                        idx_in   = req_data.position;
                        state_in = S_SHDN;
                     end else begin
                        status_in = ST_RANGE;
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            ram_ctl.rd_en   = 1'b1;
            ram_ctl.rd_addr = pos_ff[ADDR_W-1:0];
            state_in        = S_RESP;
         end
         S_SHUP: begin
            ram_ctl.wr_en   = pend_ff;
            ram_ctl.wr_addr = wr_addr_ff;
            ram_ctl.wr_data = rd_data;
            if (idx_ff != pos_ff) begin
               ram_ctl.rd_en   = 1'b1;
               ram_ctl.rd_addr = idx_dec[ADDR_W-1:0];
               wr_addr_in      = idx_ff[ADDR_W-1:0];
               idx_in          = idx_dec;
               pend_in         = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = pos_ff[ADDR_W-1:0];
            ram_ctl.wr_data = val_ff;
            count_in        = count_ff + CNT_W'(1);
            state_in        = S_RESP;
         end
         S_SHDN: begin
            ram_ctl.wr_en   = pend_ff;
            ram_ctl.wr_addr = wr_addr_ff;
            ram_ctl.wr_data = rd_data;
            if (idx_inc < count_ff) begin
               ram_ctl.rd_en   = 1'b1;
               ram_ctl.rd_addr = idx_inc[ADDR_W-1:0];
               wr_addr_in      = idx_ff[ADDR_W-1:0];
               idx_in          = idx_inc;
               pend_in         = 1'b1;
            end else begin
               pend_in  = 1'b0;
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.read_value    = rd_ok_ff ? rd_data : '0;
               rsp_data_in.status        = status_ff;
               rsp_data_in.element_count = count_ff;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      wr_addr_ff  <= wr_addr_in;
      status_ff   <= status_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.element_count <= CAP_COUNT))
      else $error("response count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |-> (rsp_data.element_count == CAP_COUNT))
      else $error("full status with list not full");

   a_value_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.read_value != '0) |-> (rsp_data.status == ST_DONE))
      else $error("read value on failed request");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer did not start on accept");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
   import ilid_pkg::*;
();

   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int PRINT_CAP   = 60;
   localparam int ACT_LAST    = (1 << ACT_W) - 1;

   localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_ONES = {VAL_W{1'b1}};
   localparam logic [POS_W-1:0]        POS_ONES = {POS_W{1'b1}};

   class list_scoreboard;
      logic signed [VAL_W-1:0] entries[$];
      rsp_type expected_q[$];
      int errors;
      int checked;
      int range_hits;
      int full_hits;
      int peak;

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(req_type r);
         rsp_type want;
         int n;
         int p;
         n = entries.size();
         want.read_value = '0;
         want.status = ST_DONE;
         case (r.action)
            ACT_READ: begin
               if (int'(r.position) < n) want.read_value = entries[r.position];
               else want.status = ST_RANGE;
            end
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
               if (r.action == ACT_INS_HEAD) p = 0;
               else if (r.action == ACT_INS_TAIL) p = n;
               else p = int'(r.position);
               if (p > n) want.status = ST_RANGE;
               else if (n >= CAPACITY) want.status = ST_FULL;
               else entries.insert(p, r.item_value);
            end
            ACT_DELETE: begin
               if (int'(r.position) < n) entries.delete(int'(r.position));
               else want.status = ST_RANGE;
            end
            default: ;
         endcase
         if (want.status == ST_RANGE) range_hits++;
         if (want.status == ST_FULL) full_hits++;
         if (entries.size() > peak) peak = entries.size();
         want.element_count = CNT_W'(entries.size());
         expected_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         checked++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf(
               "response with no request outstanding (rd %0d st %0d cnt %0d)",
               got.read_value, got.status, got.element_count));
            return;
         end
         want = expected_q.pop_front();
         if (got.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      got.read_value, want.read_value));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.element_count !== want.element_count)
            report_mismatch($sformatf("element_count %0d, expected %0d",
                                      got.element_count, want.element_count));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int sent        = 0;
   int cycle_count = 0;

   list_scoreboard sb = new();

   indexed_list_insert_delete_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   task automatic send_request(req_type r);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      sent++;
   endtask

   task automatic send_fields(logic [ACT_W-1:0] act, int pos, logic signed [VAL_W-1:0] v);
      req_type r;
      r.action     = act;
      r.position   = POS_W'(pos);
      r.item_value = v;
      send_request(r);
   endtask

   // hold the sender off until the list has answered everything
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return '0;
         3: return VAL_ONES;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type pick_request(int n);
      req_type r;
      int roll;
      r.item_value = pick_value();
      r.position   = POS_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 10) begin
         r.action = ACT_W'($urandom_range(ACT_LAST));
      end else begin
         if (roll < 32) r.action = ACT_READ;
         else if (roll < 44) r.action = ACT_INS_HEAD;
         else if (roll < 62) r.action = ACT_INS_TAIL;
         else if (roll < 78) r.action = ACT_INS_AT;
         else r.action = ACT_DELETE;
         if (r.action == ACT_READ || r.action == ACT_DELETE) begin
            if (n == 0 || $urandom_range(9) == 0) r.position = POS_W'(n);
            else r.position = POS_W'($urandom_range(n - 1));
         end else if (r.action == ACT_INS_AT) begin
            if ($urandom_range(9) == 0) r.position = POS_W'(n + 1);
            else r.position = POS_W'($urandom_range(n));
         end
      end
      return r;
   endfunction

   task automatic run_random(int items);
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(99) < 2) wait_drained();
         send_request(pick_request(sb.entries.size()));
      end
   endtask

   task automatic run_directed();
      send_fields(ACT_READ, 0, '0);
      send_fields(ACT_DELETE, 0, '0);
      send_fields(ACT_INS_AT, 1, VAL_ONES);
      send_fields(ACT_INS_HEAD, 0, VAL_MAX);
      send_fields(ACT_INS_TAIL, 0, VAL_MIN);
      send_fields(ACT_INS_AT, 1, VAL_ONES);
      send_fields(ACT_INS_AT, 3, '0);
      send_fields(ACT_INS_AT, 5, 32'h1234_5678);
      for (int p = 0; p <= 4; p++) send_fields(ACT_READ, p, '0);
      send_fields(ACT_READ, int'(POS_ONES), VAL_ONES);
      send_fields(ACT_DELETE, 1, '0);
      send_fields(ACT_DELETE, 2, '0);
      send_fields(ACT_DELETE, 0, '0);
      send_fields(ACT_DELETE, 1, '0);
      for (int a = int'(ACT_DELETE) + 1; a <= ACT_LAST; a++)
         send_fields(ACT_W'(a), int'(POS_ONES), VAL_ONES);
      send_fields(ACT_INS_HEAD, int'(POS_ONES), 32'h5555_5555);
      send_fields(ACT_INS_TAIL, 0, 32'hAAAA_AAAA);
      send_fields(ACT_READ, 1, '0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      wait_drained();
      run_random(139);

      wait_drained();
      idle_pct = 73;
      run_random(139);

      wait_drained();
      idle_pct  = 0;
      stall_pct = 73;
      run_random(139);

      wait_drained();
      idle_pct  = 24;
      stall_pct = 24;
      run_random(139);

      req_valid <= 1'b0;
      stall_pct = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses; list depth peaked at %0d of %0d.",
               sent, sb.checked, sb.peak, CAPACITY);
      $display("Saw %0d out-of-range and %0d list-full rejects across four handshake mixes.",
               sb.range_hits, sb.full_hits);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ilid_pkg.sv
rtl/ilid_ram.sv
rtl/indexed_list_insert_delete_core.sv
tb/sv/tb_top.sv
